// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define TMT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TMT_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: src/tmt_pkg.sv
`default_nettype none
package tmt_pkg;

   localparam int unsigned NUM_VERT  = 4;
   localparam int unsigned NUM_HORIZ = 4;
   localparam int unsigned NUM_OUT   = NUM_VERT + NUM_HORIZ;
   localparam int unsigned CSR_AW    = 3;
   localparam int unsigned CSR_DW    = 11;

   typedef logic [10:0]        width_type;
   typedef logic signed [7:0]  trim_type;
   typedef logic signed [12:0] sum_type;

   typedef trim_type  trim_vec_type [NUM_VERT];
   typedef width_type hold_vec_type [NUM_VERT];
   // element 0 sits in the lowest bits
   typedef logic [NUM_OUT-1:0][10:0] width_vec_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_NEUTRAL_WIDTH   = 3'd0,
      REG_NEUTRAL_BAND    = 3'd1,
      REG_VERTICAL_MIN    = 3'd2,
      REG_VERTICAL_MAX    = 3'd3,
      REG_HORIZONTAL_MIN  = 3'd4,
      REG_HORIZONTAL_MAX  = 3'd5,
      REG_TRIM_LIMIT      = 3'd6,
      REG_STICK_DEAD_ZONE = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [10:0] neutral_width;
      logic [7:0]  neutral_band;
      logic [10:0] vertical_min;
      logic [10:0] vertical_max;
      logic [10:0] horizontal_min;
      logic [10:0] horizontal_max;
      logic [6:0]  trim_limit;
      logic [7:0]  stick_dead_zone;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      neutral_width:   11'd1500,
      neutral_band:    8'd50,
      vertical_min:    11'd1000,
      vertical_max:    11'd2000,
      horizontal_min:  11'd1100,
      horizontal_max:  11'd1900,
      trim_limit:      7'd100,
      stick_dead_zone: 8'd50
   };

   localparam width_type HOLD_RESET = 11'd1500;

   typedef struct packed {
      logic               link_ok;
      logic               mode;
      logic signed [10:0] roll_correction;
      logic signed [10:0] pitch_correction;
      logic signed [9:0]  stick_vertical;
      logic signed [9:0]  stick_x;
      logic signed [9:0]  stick_y;
      logic signed [9:0]  stick_yaw;
   } item_type;

endpackage
`default_nettype wire

// File: src/tmt_limit.sv
`default_nettype none
module tmt_limit (
   input  tmt_pkg::sum_type   value,
   input  tmt_pkg::width_type lo,
   input  tmt_pkg::width_type hi,
   input  tmt_pkg::width_type neutral,
   input  logic [7:0]         band,
   output tmt_pkg::width_type width
);
   import tmt_pkg::*;

   sum_type lo_s, hi_s, n_s, band_s, band_hi, band_lo;

   always_comb begin
      lo_s    = signed'(13'(lo));
      hi_s    = signed'(13'(hi));
      n_s     = signed'(13'(neutral));
      band_s  = signed'(13'(band));
      band_hi = n_s + band_s;
      band_lo = n_s - band_s;
      // max wins over min when the pair is inverted
      if (value > hi_s) begin
         width = hi;
      end else if (value < lo_s) begin
         width = lo;
      end else if (value < band_hi && value > band_lo) begin
         width = neutral;
      end else begin
         width = value[10:0];
      end
   end

endmodule
`default_nettype wire

// File: src/tmt_trim.sv
`default_nettype none
`include "assert_macros.svh"
module tmt_trim (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  tmt_pkg::item_type     item,
   input  tmt_pkg::cfg_type      cfg,
   output tmt_pkg::trim_vec_type trim_next
);
   import tmt_pkg::*;

   trim_vec_type  trim_ff, trim_in, trim_new;
   sum_type       sum_w [NUM_VERT];
   sum_type       c0, c1, lim_p, lim_n;
   logic signed [10:0] z_s, dz_s;
   logic          dead_w;

   always_comb begin
      c0    = 13'(item.roll_correction);
      c1    = 13'(item.pitch_correction);
      lim_p = signed'(13'(cfg.trim_limit));
      lim_n = -lim_p;
      z_s   = 11'(item.stick_vertical);
      dz_s  = signed'(11'(cfg.stick_dead_zone));
      dead_w = (z_s > -dz_s) && (z_s < dz_s);

      sum_w[0] = 13'(trim_ff[0]) - c0 - c1;
      sum_w[1] = 13'(trim_ff[1]) - c0 + c1;
      sum_w[2] = 13'(trim_ff[2]) + c0 - c1;
      sum_w[3] = 13'(trim_ff[3]) + c0 + c1;

      for (int i = 0; i < NUM_VERT; i++) begin
         if (dead_w) begin
            trim_new[i] = '0;
         end else if (sum_w[i] > lim_p) begin
            trim_new[i] = lim_p[7:0];
         end else if (sum_w[i] < lim_n) begin
            trim_new[i] = lim_n[7:0];
         end else begin
            trim_new[i] = sum_w[i][7:0];
         end
         trim_in[i] = step ? trim_new[i] : trim_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_VERT; i++) begin
            trim_ff[i] <= '0;
         end
      end else begin
         trim_ff <= trim_in;
      end
   end

   assign trim_next = trim_new;

   `TMT_ASSERT(a_trim_clear, step && dead_w |=> trim_ff[0] == 0 && trim_ff[1] == 0 && trim_ff[2] == 0 && trim_ff[3] == 0, "trims not cleared in dead zone")
   `TMT_ASSERT(a_trim_hold, !step |=> $stable(trim_ff[0]) && $stable(trim_ff[1]) && $stable(trim_ff[2]) && $stable(trim_ff[3]), "trims moved without a thruster word")

endmodule
`default_nettype wire

// File: src/tmt_mixer.sv
`default_nettype none
module tmt_mixer (
   input  tmt_pkg::item_type      item,
   input  tmt_pkg::cfg_type       cfg,
   input  tmt_pkg::trim_vec_type  trim,
   input  tmt_pkg::hold_vec_type  hold,
   output tmt_pkg::width_vec_type widths
);
   import tmt_pkg::*;

   sum_type   n_s, z_s, x_s, y_s, yaw_s;
   sum_type   vraw [NUM_VERT];
   sum_type   hraw [NUM_HORIZ];
   width_type vlim [NUM_VERT];
   width_type hlim [NUM_HORIZ];

   always_comb begin
      n_s   = signed'(13'(cfg.neutral_width));
      z_s   = 13'(item.stick_vertical);
      x_s   = 13'(item.stick_x);
      y_s   = 13'(item.stick_y);
      yaw_s = 13'(item.stick_yaw);

      vraw[0] = n_s - z_s + 13'(trim[0]);
      vraw[1] = n_s + z_s + 13'(trim[1]);
      vraw[2] = n_s + z_s + 13'(trim[2]);
      vraw[3] = n_s - z_s + 13'(trim[3]);

      hraw[0] = n_s - yaw_s - x_s - y_s;
      hraw[1] = n_s - yaw_s + x_s - y_s;
      hraw[2] = n_s - yaw_s - x_s + y_s;
      hraw[3] = n_s + yaw_s - x_s - y_s;
   end

   for (genvar g = 0; g < NUM_VERT; g++) begin : g_vert
      tmt_limit u_lim (
         .value   (vraw[g]),
         .lo      (cfg.vertical_min),
         .hi      (cfg.vertical_max),
         .neutral (cfg.neutral_width),
         .band    (cfg.neutral_band),
         .width   (vlim[g])
      );
   end

   for (genvar g = 0; g < NUM_HORIZ; g++) begin : g_horiz
      tmt_limit u_lim (
         .value   (hraw[g]),
         .lo      (cfg.horizontal_min),
         .hi      (cfg.horizontal_max),
         .neutral (cfg.neutral_width),
         .band    (cfg.neutral_band),
         .width   (hlim[g])
      );
   end

   // vertical outputs double as the next hold values
   always_comb begin
      for (int i = 0; i < NUM_VERT; i++) begin
         if (!item.link_ok) begin
            widths[i]            = cfg.neutral_width;
            widths[i + NUM_VERT] = cfg.neutral_width;
         end else if (item.mode) begin
            widths[i]            = vlim[i];
            widths[i + NUM_VERT] = hlim[i];
         end else begin
            widths[i]            = hold[i];
            widths[i + NUM_VERT] = cfg.neutral_width;
         end
      end
   end

endmodule
`default_nettype wire

// File: src/thruster_mixer_with_tilt_trim.sv
// Channel   Dir   Contents
// req_      in    tdata: roll, pitch, stick vertical, x, y, yaw; tuser: link_ok, mode
// rsp_      out   tdata: vertical widths 0..3, horizontal widths 0..3
// csr_      in    write enable, 3-bit register index, 11-bit data
//
// One word per cycle sustained while rsp_ is ready; a taken word passes the input register,
// then the mixer and limiters into the result register, before it shows on rsp_.
// Trim and hold state update as a word moves into the result register, so
// consecutive words see each other's effect in order.
// A stalled rsp_ holds the result register; req_ still takes one more word.
// Synchronous reset restores register defaults, clears trims, sets holds to 1500.
`default_nettype none
`include "assert_macros.svh"
module thruster_mixer_with_tilt_trim (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [10:0] roll_correction, [21:11] pitch_correction, [31:22] stick_vertical,
   // [41:32] stick_x, [51:42] stick_y, [61:52] stick_yaw, [63:62] zero
   input  logic [63:0] req_tdata,
   // [0] link_ok, [1] mode
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [10:0] vert_width_0 .. [43:33] vert_width_3,
   // [54:44] horiz_width_0 .. [87:77] horiz_width_3
   output logic [87:0] rsp_tdata,
   input  logic                        csr_we,
   input  logic [tmt_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [tmt_pkg::CSR_DW-1:0]  csr_wdata
);
   import tmt_pkg::*;

   cfg_type       cfg_ff, cfg_in;
   logic          s1_valid_ff, s1_valid_in;
   item_type      s1_item_ff, s1_item_in;
   logic          out_valid_ff, out_valid_in;
   width_vec_type out_data_ff, out_data_in;
   hold_vec_type  hold_ff, hold_in;
   trim_vec_type  trim_next;
   width_vec_type widths;
   item_type      req_item;
   logic          req_accept, s1_adv, trim_step;

   always_comb begin
      req_item.link_ok          = req_tuser[0];
      req_item.mode             = req_tuser[1];
      req_item.roll_correction  = req_tdata[10:0];
      req_item.pitch_correction = req_tdata[21:11];
      req_item.stick_vertical   = req_tdata[31:22];
      req_item.stick_x          = req_tdata[41:32];
      req_item.stick_y          = req_tdata[51:42];
      req_item.stick_yaw        = req_tdata[61:52];
   end

   assign s1_adv     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_accept = req_tvalid && req_tready;
   assign trim_step  = s1_adv && s1_item_ff.link_ok && s1_item_ff.mode;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_NEUTRAL_WIDTH:   cfg_in.neutral_width   = csr_wdata[10:0];
            REG_NEUTRAL_BAND:    cfg_in.neutral_band    = csr_wdata[7:0];
            REG_VERTICAL_MIN:    cfg_in.vertical_min    = csr_wdata[10:0];
            REG_VERTICAL_MAX:    cfg_in.vertical_max    = csr_wdata[10:0];
            REG_HORIZONTAL_MIN:  cfg_in.horizontal_min  = csr_wdata[10:0];
            REG_HORIZONTAL_MAX:  cfg_in.horizontal_max  = csr_wdata[10:0];
            REG_TRIM_LIMIT:      cfg_in.trim_limit      = csr_wdata[6:0];
            REG_STICK_DEAD_ZONE: cfg_in.stick_dead_zone = csr_wdata[7:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      s1_valid_in  = req_accept ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_ff);
      s1_item_in   = req_accept ? req_item : s1_item_ff;
      out_valid_in = s1_adv ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      out_data_in  = s1_adv ? widths : out_data_ff;
      for (int i = 0; i < NUM_VERT; i++) begin
         hold_in[i] = s1_adv ? widths[i] : hold_ff[i];
      end
   end

   tmt_trim u_trim (
      .clock     (clock),
      .reset     (reset),
      .step      (trim_step),
      .item      (s1_item_ff),
      .cfg       (cfg_ff),
      .trim_next (trim_next)
   );

   tmt_mixer u_mixer (
      .item   (s1_item_ff),
      .cfg    (cfg_ff),
      .trim   (trim_next),
      .hold   (hold_ff),
      .widths (widths)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_VERT; i++) begin
            hold_ff[i] <= HOLD_RESET;
         end
      end else begin
         cfg_ff       <= cfg_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         hold_ff      <= hold_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   `TMT_ASSERT_RST(a_reset_idle, reset |=> !rsp_tvalid && req_tready, "not idle after reset")
   `TMT_ASSERT(a_adv_out, s1_adv |=> rsp_tvalid, "advanced word did not reach the result register")
   `TMT_ASSERT(a_nolink_neutral, s1_adv && !s1_item_ff.link_ok |=> rsp_tdata[10:0] == cfg_ff.neutral_width && rsp_tdata[54:44] == cfg_ff.neutral_width, "no-link word not neutral")

endmodule
`default_nettype wire

// File: bench/tb_thruster_mixer_with_tilt_trim.sv
module tb_thruster_mixer_with_tilt_trim;

   localparam bit LINK_UP        = 1'b1;
   localparam bit LINK_DOWN      = 1'b0;
   localparam bit MODE_THRUSTER  = 1'b1;
   localparam bit MODE_MANIP     = 1'b0;
   localparam int WORDS_PER_SET  = 190;
   localparam int NUM_SETTINGS   = 8;
   localparam int SETTLE_CYCLES  = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [tmt_pkg::CSR_AW-1:0] csr_addr = '0;
   logic [tmt_pkg::CSR_DW-1:0] csr_wdata = '0;

   thruster_mixer_with_tilt_trim dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial forever #1 clock = ~clock;

   // mirror of the block's registers and state
   tmt_pkg::cfg_type       cfg_shadow = tmt_pkg::CFG_RESET;
   int                     tilt_trim [4] = '{0, 0, 0, 0};
   tmt_pkg::width_type     vert_hold [4] = '{4{tmt_pkg::HOLD_RESET}};

   tmt_pkg::item_type      tick_q [$];
   tmt_pkg::width_vec_type widths_due_q [$];
   tmt_pkg::item_type      cur_item;

   int  src_wait = 0;
   int  snk_wait = 0;
   bit  src_busy = 1'b0;
   bit  snk_busy = 1'b0;
   int  bad_count = 0;
   int  n_checked = 0;
   int  n_thrust = 0;
   int  n_manip = 0;
   int  n_lost = 0;

   function automatic int draw_pause(bit busy);
      return busy ? 0 : $urandom_range(0, 16);
   endfunction

   function automatic int clamp_trim(int v);
      int lim;
      lim = int'(cfg_shadow.trim_limit);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   // order matters: max, then min, then the neutral snap
   function automatic tmt_pkg::width_type limit_width(int v, int lo, int hi);
      int n, b;
      n = int'(cfg_shadow.neutral_width);
      b = int'(cfg_shadow.neutral_band);
      if (v > hi) return hi[10:0];
      if (v < lo) return lo[10:0];
      if (v < n + b && v > n - b) return n[10:0];
      return v[10:0];
   endfunction

   function automatic void mix_tick(tmt_pkg::item_type it);
      tmt_pkg::width_vec_type w;
      int n, dz, c0, c1, z, x, y, yaw, vlo, vhi, hlo, hhi;
      n   = int'(cfg_shadow.neutral_width);
      dz  = int'(cfg_shadow.stick_dead_zone);
      vlo = int'(cfg_shadow.vertical_min);
      vhi = int'(cfg_shadow.vertical_max);
      hlo = int'(cfg_shadow.horizontal_min);
      hhi = int'(cfg_shadow.horizontal_max);
      c0  = int'(it.roll_correction);
      c1  = int'(it.pitch_correction);
      z   = int'(it.stick_vertical);
      x   = int'(it.stick_x);
      y   = int'(it.stick_y);
      yaw = int'(it.stick_yaw);
      if (it.link_ok == LINK_DOWN) begin
         foreach (vert_hold[i]) vert_hold[i] = cfg_shadow.neutral_width;
         for (int k = 0; k < tmt_pkg::NUM_OUT; k++) w[k] = cfg_shadow.neutral_width;
         n_lost++;
      end else if (it.mode == MODE_THRUSTER) begin
         tilt_trim[0] = clamp_trim(tilt_trim[0] - c0 - c1);
         tilt_trim[1] = clamp_trim(tilt_trim[1] - c0 + c1);
         tilt_trim[2] = clamp_trim(tilt_trim[2] + c0 - c1);
         tilt_trim[3] = clamp_trim(tilt_trim[3] + c0 + c1);
         if (z > -dz && z < dz) begin
            foreach (tilt_trim[i]) tilt_trim[i] = 0;
         end
         vert_hold[0] = limit_width(n - z + tilt_trim[0], vlo, vhi);
         vert_hold[1] = limit_width(n + z + tilt_trim[1], vlo, vhi);
         vert_hold[2] = limit_width(n + z + tilt_trim[2], vlo, vhi);
         vert_hold[3] = limit_width(n - z + tilt_trim[3], vlo, vhi);
         foreach (vert_hold[i]) w[i] = vert_hold[i];
         w[4] = limit_width(n - yaw - x - y, hlo, hhi);
         w[5] = limit_width(n - yaw + x - y, hlo, hhi);
         w[6] = limit_width(n - yaw - x + y, hlo, hhi);
         w[7] = limit_width(n + yaw - x - y, hlo, hhi);
         n_thrust++;
      end else begin
         foreach (vert_hold[i]) begin
            w[i]     = vert_hold[i];
            w[i + 4] = cfg_shadow.neutral_width;
         end
         n_manip++;
      end
      widths_due_q.push_back(w);
   endfunction

   function automatic tmt_pkg::item_type make_item(bit link, bit thr, int roll, int pitch,
                                                   int z, int x, int y, int yaw);
      tmt_pkg::item_type it;
      it.link_ok          = link;
      it.mode             = thr;
      it.roll_correction  = 11'(roll);
      it.pitch_correction = 11'(pitch);
      it.stick_vertical   = 10'(z);
      it.stick_x          = 10'(x);
      it.stick_y          = 10'(y);
      it.stick_yaw        = 10'(yaw);
      return it;
   endfunction

   function automatic int rand_corr();
      case ($urandom_range(0, 7))
         0: return int'($urandom_range(0, 2047)) - 1024;
         1: return $urandom_range(0, 1) ? 1023 : -1024;
         default: return int'($urandom_range(0, 80)) - 40;
      endcase
   endfunction

   function automatic int rand_stick();
      case ($urandom_range(0, 7))
         0, 1, 2, 3: return int'($urandom_range(0, 1023)) - 512;
         4: return $urandom_range(0, 1) ? 511 : -512;
         default: return int'($urandom_range(0, 128)) - 64;
      endcase
   endfunction

   function automatic tmt_pkg::item_type rand_item();
      int  kind;
      bit  link, thr;
      kind = $urandom_range(0, 99);
      link = (kind >= 12) ? LINK_UP : LINK_DOWN;
      thr  = (kind < 12) ? 1'($urandom_range(0, 1)) :
             (kind < 27) ? MODE_MANIP : MODE_THRUSTER;
      return make_item(link, thr, rand_corr(), rand_corr(),
                       rand_stick(), rand_stick(), rand_stick(), rand_stick());
   endfunction

   // input side: one word per draw, a random pause before each
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_wait = draw_pause(src_busy);
      end else begin
         if (req_tvalid && req_tready) mix_tick(cur_item);
         if (!req_tvalid || req_tready) begin
            if (src_wait > 0 || tick_q.size() == 0) begin
               if (src_wait > 0) src_wait--;
               req_tvalid <= 1'b0;
            end else begin
               cur_item = tick_q.pop_front();
               req_tdata <= {2'b00, cur_item.stick_yaw, cur_item.stick_y, cur_item.stick_x,
                             cur_item.stick_vertical, cur_item.pitch_correction,
                             cur_item.roll_correction};
               req_tuser <= {cur_item.mode, cur_item.link_ok};
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 49) == 0) src_busy = !src_busy;
               src_wait = draw_pause(src_busy);
            end
         end
      end
   end

   task automatic check_widths(logic [87:0] got);
      tmt_pkg::width_vec_type want;
      string fname;
      if (widths_due_q.size() == 0) begin
         $error("result word arrived with no prediction pending: %h", got);
         bad_count++;
      end else begin
         want = widths_due_q.pop_front();
         n_checked++;
         for (int k = 0; k < tmt_pkg::NUM_OUT; k++) begin
            if (got[k*11 +: 11] !== want[k]) begin
               fname = (k < 4) ? $sformatf("vert_width_%0d", k) :
                                 $sformatf("horiz_width_%0d", k - 4);
               $error("%s: expected %0d, got %0d", fname, want[k], got[k*11 +: 11]);
               bad_count++;
            end
         end
      end
   endtask

   // result side: random stall after every word taken
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         snk_wait = draw_pause(snk_busy);
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_widths(rsp_tdata);
            if ($urandom_range(0, 49) == 0) snk_busy = !snk_busy;
            snk_wait = draw_pause(snk_busy);
         end
         if (snk_wait > 0) begin
            snk_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic write_reg(tmt_pkg::reg_index_type idx, logic [10:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= data;
      case (idx)
         tmt_pkg::REG_NEUTRAL_WIDTH:   cfg_shadow.neutral_width   = data;
         tmt_pkg::REG_NEUTRAL_BAND:    cfg_shadow.neutral_band    = data[7:0];
         tmt_pkg::REG_VERTICAL_MIN:    cfg_shadow.vertical_min    = data;
         tmt_pkg::REG_VERTICAL_MAX:    cfg_shadow.vertical_max    = data;
         tmt_pkg::REG_HORIZONTAL_MIN:  cfg_shadow.horizontal_min  = data;
         tmt_pkg::REG_HORIZONTAL_MAX:  cfg_shadow.horizontal_max  = data;
         tmt_pkg::REG_TRIM_LIMIT:      cfg_shadow.trim_limit      = data[6:0];
         tmt_pkg::REG_STICK_DEAD_ZONE: cfg_shadow.stick_dead_zone = data[7:0];
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // narrow registers get junk above their width, which must be dropped
   task automatic load_settings(tmt_pkg::cfg_type c);
      logic [10:0] junk;
      junk = 11'($urandom);
      write_reg(tmt_pkg::REG_NEUTRAL_WIDTH, c.neutral_width);
      write_reg(tmt_pkg::REG_NEUTRAL_BAND, {junk[10:8], c.neutral_band});
      write_reg(tmt_pkg::REG_VERTICAL_MIN, c.vertical_min);
      write_reg(tmt_pkg::REG_VERTICAL_MAX, c.vertical_max);
      write_reg(tmt_pkg::REG_HORIZONTAL_MIN, c.horizontal_min);
      write_reg(tmt_pkg::REG_HORIZONTAL_MAX, c.horizontal_max);
      write_reg(tmt_pkg::REG_TRIM_LIMIT, {junk[10:7], c.trim_limit});
      write_reg(tmt_pkg::REG_STICK_DEAD_ZONE, {junk[2:0], c.stick_dead_zone});
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (tick_q.size() != 0 || req_tvalid || widths_due_q.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      tmt_pkg::cfg_type s;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // link lost, with either mode bit
      tick_q.push_back(make_item(LINK_DOWN, MODE_THRUSTER, 1023, -1024, 511, -512, 511, -512));
      tick_q.push_back(make_item(LINK_DOWN, MODE_MANIP, -1024, 1023, -512, 511, -512, 511));
      // manipulator before any thruster word: holds still at reset value
      tick_q.push_back(make_item(LINK_UP, MODE_MANIP, 500, -500, 300, 300, 300, 300));
      // trims driven into both clamps by full-scale corrections
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 1023, 1023, 511, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 1023, -1024, 511, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, -1024, -1024, -512, 0, 0, 0));
      // vertical stick inside and on the dead zone edges
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 30, 20, 0, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 10, -5, 49, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 10, -5, 50, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, -7, 3, -49, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, -7, 3, -50, 0, 0, 0));
      // horizontal mix at the stick extremes, and around the neutral band
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 200, 511, 511, 511));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, -200, -512, -512, -512));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 100, 0, 0, -512));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 100, 50, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 100, 49, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 100, -50, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_THRUSTER, 0, 0, 100, 1, -1, 0));
      // manipulator repeats the last vertical widths
      tick_q.push_back(make_item(LINK_UP, MODE_MANIP, 200, 200, -300, 400, -400, 100));
      tick_q.push_back(make_item(LINK_UP, MODE_MANIP, -200, 0, 300, -400, 400, -100));
      // link loss resets the holds to neutral
      tick_q.push_back(make_item(LINK_DOWN, MODE_THRUSTER, 0, 0, 300, 0, 0, 0));
      tick_q.push_back(make_item(LINK_UP, MODE_MANIP, 0, 0, 300, 0, 0, 0));

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         if (p != 0) begin
            wait_drained();
            case (p)
               1: s = '{neutral_width: 11'd1000, neutral_band: 8'd0,
                        vertical_min: 11'd0, vertical_max: 11'd2047,
                        horizontal_min: 11'd0, horizontal_max: 11'd2047,
                        trim_limit: 7'd127, stick_dead_zone: 8'd0};
               // inverted limit pairs, widest band and dead zone, no trim
               2: s = '{neutral_width: 11'd2000, neutral_band: 8'd255,
                        vertical_min: 11'd2047, vertical_max: 11'd0,
                        horizontal_min: 11'd1500, horizontal_max: 11'd1400,
                        trim_limit: 7'd0, stick_dead_zone: 8'd255};
               NUM_SETTINGS - 1: s = tmt_pkg::CFG_RESET;
               default: begin
                  s.neutral_width   = 11'($urandom_range(1000, 2000));
                  s.neutral_band    = 8'($urandom_range(0, 255));
                  s.vertical_min    = 11'($urandom_range(0, 1300));
                  s.vertical_max    = 11'($urandom_range(1700, 2047));
                  s.horizontal_min  = 11'($urandom_range(0, 1300));
                  s.horizontal_max  = 11'($urandom_range(1700, 2047));
                  s.trim_limit      = 7'($urandom_range(0, 127));
                  s.stick_dead_zone = 8'($urandom_range(0, 255));
                  if ($urandom_range(0, 2) == 0) begin
                     s.vertical_min   = 11'($urandom);
                     s.horizontal_max = 11'($urandom);
                  end
               end
            endcase
            load_settings(s);
         end
         repeat (WORDS_PER_SET) tick_q.push_back(rand_item());
      end

      wait_drained();
      $display("Checked %0d result words: %0d thruster, %0d manipulator, %0d link lost",
               n_checked, n_thrust, n_manip, n_lost);
      $display("across %0d register settings, limits inverted and at both extremes",
               NUM_SETTINGS);
      if (bad_count == 0 && widths_due_q.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Timeout with %0d results outstanding", widths_due_q.size());
      $display("Mismatches found");
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/tmt_pkg.sv
src/tmt_limit.sv
src/tmt_trim.sv
src/tmt_mixer.sv
src/thruster_mixer_with_tilt_trim.sv
bench/tb_thruster_mixer_with_tilt_trim.sv
